FILE: src/aabbt_pkg.sv
// ----------------------------------------------------------------------------
// aabbt_pkg
// Shared field widths, command codes and the control/status bundles that
// join the collider table controller and datapath.
// ----------------------------------------------------------------------------
package aabbt_pkg;

    // Fixed field widths of one request and one response item.
    localparam int CMD_W = 2;
    localparam int ID_W  = 4;
    localparam int POS_W = 16;
    localparam int DIM_W = 15;

    // Command codes carried in the cmd field.
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_MOVE   = 2'd3;

    // One request item as it enters the datapath.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [ID_W-1:0]  entry_id;
        logic             use_except;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] rel_x;
        logic [POS_W-1:0] rel_y;
        logic [DIM_W-1:0] box_width;
        logic [DIM_W-1:0] box_height;
    } t_req_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;        // capture the request and restart the scan
        logic scan_inc;    // step the scan index
        logic do_remove;   // clear the valid bit of the addressed slot
        logic do_move;     // rewrite the corner of the addressed slot
        logic add_commit;  // store the box in the slot under the scan index
        logic set_full;    // flag that no free slot was found
        logic qry_en;      // read the slot under the scan index for a query
        logic out_load;    // move the finished result into the output register
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             slot_free;
        logic             scan_last;
        logic             out_free;
    } t_ctl_sts;

endpackage

FILE: src/aabbt_req_if.sv
// ----------------------------------------------------------------------------
// aabbt_req_if
// Request channel: valid/ready handshake carrying one command item.
// ----------------------------------------------------------------------------
interface aabbt_req_if;
    import aabbt_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic [ID_W-1:0]         entry_id;
    logic                    use_except;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] rel_x;
    logic signed [POS_W-1:0] rel_y;
    logic [DIM_W-1:0]        box_width;
    logic [DIM_W-1:0]        box_height;

    modport source (
        output valid, cmd, entry_id, use_except, pos_x, pos_y, rel_x, rel_y,
               box_width, box_height,
        input  ready
    );

    modport sink (
        input  valid, cmd, entry_id, use_except, pos_x, pos_y, rel_x, rel_y,
               box_width, box_height,
        output ready
    );
endinterface

FILE: src/aabbt_rsp_if.sv
// ----------------------------------------------------------------------------
// aabbt_rsp_if
// Response channel: valid/ready handshake carrying one result item.
// ----------------------------------------------------------------------------
interface aabbt_rsp_if;
    import aabbt_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] new_id;
    logic            hit;
    logic            full_res;

    modport source (
        output valid, new_id, hit, full_res,
        input  ready
    );

    modport sink (
        input  valid, new_id, hit, full_res,
        output ready
    );
endinterface

FILE: src/aabbt_ram.sv
// ----------------------------------------------------------------------------
// aabbt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module aabbt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: src/aabbt_ctrl.sv
// ----------------------------------------------------------------------------
// aabbt_ctrl
// Sequencer for the collider table: dispatches each item, walks the slot
// scan for add and query, and hands the result to the output register.
// ----------------------------------------------------------------------------
module aabbt_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  aabbt_pkg::t_ctl_sts i_sts,
    output aabbt_pkg::t_ctl_cmd o_cmd
);
    import aabbt_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE     = 6'b000001,
        S_DISPATCH = 6'b000010,
        S_ADD      = 6'b000100,
        S_QUERY    = 6'b001000,
        S_DRAIN    = 6'b010000,
        S_FINISH   = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    // Next-state and command decode.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                unique case (i_sts.cmd)
                    CMD_ADD: begin
                        n_state = S_ADD;
                    end
                    CMD_QUERY: begin
                        n_state = S_QUERY;
                    end
                    CMD_REMOVE: begin
                        o_cmd.do_remove = 1'b1;
                        n_state         = S_FINISH;
                    end
                    CMD_MOVE: begin
                        o_cmd.do_move = 1'b1;
                        n_state       = S_FINISH;
                    end
                    default: begin
                        n_state = S_FINISH;
                    end
                endcase
            end
            S_ADD: begin
                // Lowest free slot wins; the scan ends at the last slot.
                if (i_sts.slot_free) begin
                    o_cmd.add_commit = 1'b1;
                    n_state          = S_FINISH;
                end else if (i_sts.scan_last) begin
                    o_cmd.set_full = 1'b1;
                    n_state        = S_FINISH;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_QUERY: begin
                o_cmd.qry_en = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end else begin
                    o_cmd.scan_inc = 1'b1;
                end
            end
            S_DRAIN: begin
                // The last slot read is compared during this cycle.
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> (r_state == S_DISPATCH))
        else $error("accepted item did not move to dispatch");

    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> i_sts.out_free)
        else $error("result loaded while output register still occupied");

    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.add_commit |-> i_sts.slot_free)
        else $error("add committed into an occupied slot");
`endif
endmodule

FILE: src/aabbt_dp.sv
// ----------------------------------------------------------------------------
// aabbt_dp
// Datapath of the collider table: request registers, corner saturation,
// box RAMs, valid bits, scan index, overlap compare and output register.
// ----------------------------------------------------------------------------
module aabbt_dp #(
    parameter int NUM_ENTRIES = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  aabbt_pkg::t_req_item i_item,
    input  aabbt_pkg::t_ctl_cmd  i_cmd,
    output aabbt_pkg::t_ctl_sts  o_sts,
    aabbt_rsp_if.source          o_rsp
);
    import aabbt_pkg::*;

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int IDW   = (IDX_W > ID_W) ? IDX_W : ID_W;
    localparam int SUM_W = ((COORD_BITS > POS_W + 1) ? COORD_BITS : POS_W + 1) + 1;
    localparam int CMP_W = ((COORD_BITS > POS_W) ? COORD_BITS : POS_W) + 2;

    localparam logic signed [SUM_W-1:0] C_HI =
        {{(SUM_W - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] C_LO = ~C_HI;

    // Request registers.
    logic [CMD_W-1:0]             r_cmd;
    logic [ID_W-1:0]              r_id;
    logic                         r_skip;
    logic signed [COORD_BITS-1:0] r_ax;
    logic signed [COORD_BITS-1:0] r_ay;
    logic [DIM_W-1:0]             r_w;
    logic [DIM_W-1:0]             r_h;

    // Scan, result and table state.
    logic [IDX_W-1:0]       r_idx;
    logic                   r_cmp_vld;
    logic                   r_hit;
    logic                   r_full;
    logic [ID_W-1:0]        r_new_id;
    logic [NUM_ENTRIES-1:0] r_valid;

    // Output register.
    logic            r_out_vld;
    logic [ID_W-1:0] r_out_new_id;
    logic            r_out_hit;
    logic            r_out_full;

    logic signed [SUM_W-1:0]      sum_x;
    logic signed [SUM_W-1:0]      sum_y;
    logic signed [COORD_BITS-1:0] sat_x;
    logic signed [COORD_BITS-1:0] sat_y;
    logic [IDW-1:0]               id_ext;
    logic [IDW-1:0]               idx_ext;
    logic [IDX_W-1:0]             id_idx;
    logic                         id_in_range;
    logic                         skip_here;

    logic                           corner_we;
    logic [IDX_W-1:0]               corner_waddr;
    logic [2*COORD_BITS-1:0]        corner_rdata;
    logic [2*DIM_W-1:0]             extent_rdata;
    logic signed [COORD_BITS-1:0]   rd_cx;
    logic signed [COORD_BITS-1:0]   rd_cy;
    logic [DIM_W-1:0]               rd_cw;
    logic [DIM_W-1:0]               rd_ch;
    logic signed [CMP_W-1:0]        ax_e;
    logic signed [CMP_W-1:0]        ay_e;
    logic signed [CMP_W-1:0]        w_e;
    logic signed [CMP_W-1:0]        h_e;
    logic signed [CMP_W-1:0]        cx_e;
    logic signed [CMP_W-1:0]        cy_e;
    logic signed [CMP_W-1:0]        cw_e;
    logic signed [CMP_W-1:0]        ch_e;
    logic                           overlap;

    // Corner = position + offset, clamped to the signed coordinate range.
    assign sum_x = SUM_W'(signed'(i_item.pos_x)) + SUM_W'(signed'(i_item.rel_x));
    assign sum_y = SUM_W'(signed'(i_item.pos_y)) + SUM_W'(signed'(i_item.rel_y));

    always_comb begin
        if (sum_x > C_HI) begin
            sat_x = C_HI[COORD_BITS-1:0];
        end else if (sum_x < C_LO) begin
            sat_x = C_LO[COORD_BITS-1:0];
        end else begin
            sat_x = sum_x[COORD_BITS-1:0];
        end
        if (sum_y > C_HI) begin
            sat_y = C_HI[COORD_BITS-1:0];
        end else if (sum_y < C_LO) begin
            sat_y = C_LO[COORD_BITS-1:0];
        end else begin
            sat_y = sum_y[COORD_BITS-1:0];
        end
    end

    // Slot addressed by entry_id, and whether it exists in this table.
    assign id_ext      = IDW'(r_id);
    assign idx_ext     = IDW'(r_idx);
    assign id_idx      = id_ext[IDX_W-1:0];
    assign id_in_range = (32'(r_id) < 32'(NUM_ENTRIES));
    assign skip_here   = r_skip && id_in_range && (id_idx == r_idx);

    // Box storage: corners are rewritten by add and move, extents by add only.
    assign corner_we    = i_cmd.add_commit || (i_cmd.do_move && id_in_range);
    assign corner_waddr = i_cmd.add_commit ? r_idx : id_idx;

    aabbt_ram #(
        .WIDTH (2 * COORD_BITS),
        .DEPTH (NUM_ENTRIES)
    ) u_corner_ram (
        .i_clk   (i_clk),
        .i_we    (corner_we),
        .i_waddr (corner_waddr),
        .i_wdata ({r_ax, r_ay}),
        .i_raddr (r_idx),
        .o_rdata (corner_rdata)
    );

    aabbt_ram #(
        .WIDTH (2 * DIM_W),
        .DEPTH (NUM_ENTRIES)
    ) u_extent_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.add_commit),
        .i_waddr (r_idx),
        .i_wdata ({r_w, r_h}),
        .i_raddr (r_idx),
        .o_rdata (extent_rdata)
    );

    // Strict overlap of the query box with the slot read last cycle.
    assign rd_cx = corner_rdata[2*COORD_BITS-1:COORD_BITS];
    assign rd_cy = corner_rdata[COORD_BITS-1:0];
    assign rd_cw = extent_rdata[2*DIM_W-1:DIM_W];
    assign rd_ch = extent_rdata[DIM_W-1:0];

    assign ax_e = CMP_W'(r_ax);
    assign ay_e = CMP_W'(r_ay);
    assign w_e  = signed'(CMP_W'(r_w));
    assign h_e  = signed'(CMP_W'(r_h));
    assign cx_e = CMP_W'(rd_cx);
    assign cy_e = CMP_W'(rd_cy);
    assign cw_e = signed'(CMP_W'(rd_cw));
    assign ch_e = signed'(CMP_W'(rd_ch));

    assign overlap = (ax_e + w_e > cx_e) && (ax_e < cx_e + cw_e) &&
                     (ay_e + h_e > cy_e) && (ay_e < cy_e + ch_e);

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd  <= i_item.cmd;
            r_id   <= i_item.entry_id;
            r_skip <= i_item.use_except;
            r_ax   <= sat_x;
            r_ay   <= sat_y;
            r_w    <= i_item.box_width;
            r_h    <= i_item.box_height;
        end
        if (i_cmd.load) begin
            r_new_id <= '0;
        end else if (i_cmd.add_commit) begin
            r_new_id <= idx_ext[ID_W-1:0];
        end
    end

    // Scan index, compare pipeline, result flags and valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_cmp_vld <= 1'b0;
            r_hit     <= 1'b0;
            r_full    <= 1'b0;
            r_valid   <= '0;
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.scan_inc) begin
                r_idx <= r_idx + 1'b1;
            end

            r_cmp_vld <= i_cmd.qry_en && r_valid[r_idx] && !skip_here;

            if (i_cmd.load) begin
                r_hit <= 1'b0;
            end else if (r_cmp_vld && overlap) begin
                r_hit <= 1'b1;
            end

            if (i_cmd.load) begin
                r_full <= 1'b0;
            end else if (i_cmd.set_full) begin
                r_full <= 1'b1;
            end

            if (i_cmd.add_commit) begin
                r_valid[r_idx] <= 1'b1;
            end else if (i_cmd.do_remove && id_in_range) begin
                r_valid[id_idx] <= 1'b0;
            end
        end
    end

    // Output register: holds one result while the next item is worked on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_new_id <= r_new_id;
            r_out_hit    <= r_hit;
            r_out_full   <= r_full;
        end
    end

    assign o_rsp.valid    = r_out_vld;
    assign o_rsp.new_id   = r_out_new_id;
    assign o_rsp.hit      = r_out_hit;
    assign o_rsp.full_res = r_out_full;

    // Status back to the controller.
    assign o_sts.cmd       = r_cmd;
    assign o_sts.slot_free = !r_valid[r_idx];
    assign o_sts.scan_last = (r_idx == IDX_W'(NUM_ENTRIES - 1));
    assign o_sts.out_free  = !r_out_vld || o_rsp.ready;

`ifndef NO_ASSERTIONS
    a_commit_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.add_commit |=> r_valid[$past(r_idx)])
        else $error("slot not valid after add");

    a_full_means_all_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |-> (&r_valid))
        else $error("full flagged while a slot is free");

    a_hit_only_on_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hit |-> (r_cmd == CMD_QUERY))
        else $error("hit raised for a command other than query");
`endif
endmodule

FILE: src/aabb_collider_table_core.sv
// ----------------------------------------------------------------------------
// aabb_collider_table_core
// Broadphase table of axis-aligned boxes with add, remove, query and move.
// ----------------------------------------------------------------------------
// The block takes one command item at a time and returns exactly one result
// item for each. Remove and move act in dispatch and then load their result.
// Add walks the slots from index 0 and stops at the first free one, or flags
// the table as full when the last slot is not free either. Query reads every
// slot once through the read port of the box RAMs, one slot per cycle, then
// compares the last slot read before it finishes. A new item is accepted
// only after the previous one is finished. A finished result sits in an
// output register, so the next item is accepted while the previous result
// waits to be taken. The valid bits are cleared by reset directly; no
// clearing pass is needed.
module aabb_collider_table_core #(
    parameter int NUM_ENTRIES = 16,
    parameter int COORD_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    aabbt_req_if.sink   i_req,
    aabbt_rsp_if.source o_rsp
);
    import aabbt_pkg::*;

    t_req_item item;
    t_ctl_cmd  ctl_cmd;
    t_ctl_sts  ctl_sts;
    logic      in_ready;

    // Gather the request payload into one bundle for the datapath.
    assign item.cmd        = i_req.cmd;
    assign item.entry_id   = i_req.entry_id;
    assign item.use_except = i_req.use_except;
    assign item.pos_x      = i_req.pos_x;
    assign item.pos_y      = i_req.pos_y;
    assign item.rel_x      = i_req.rel_x;
    assign item.rel_y      = i_req.rel_y;
    assign item.box_width  = i_req.box_width;
    assign item.box_height = i_req.box_height;

    assign i_req.ready = in_ready;

    aabbt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (in_ready),
        .i_sts      (ctl_sts),
        .o_cmd      (ctl_cmd)
    );

    aabbt_dp #(
        .NUM_ENTRIES (NUM_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cmd   (ctl_cmd),
        .o_sts   (ctl_sts),
        .o_rsp   (o_rsp)
    );
endmodule
